// ----- sv/bwsk_pkg.sv -----
// ---------------------------------------------------------------------------
// bwsk_pkg
// Shared types and constants of the Blackman-windowed sinc kernel.
// ---------------------------------------------------------------------------
package bwsk_pkg;

   localparam logic [7:0]  MAX_HALF_WIDTH   = 8'd128;
   localparam logic [7:0]  HALF_WIDTH_RESET = 8'd4;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // reciprocal scale for exact division by small constants
   localparam int RECIP_SHIFT = 34;

   localparam int HORNER_STEPS  = 5;
   localparam int SINE_LATENCY  = 3 * HORNER_STEPS + 3;

   localparam logic [6:0] HORNER_DIV [HORNER_STEPS] = '{
      7'd110, 7'd72, 7'd42, 7'd20, 7'd6
   };
   localparam logic [31:0] HORNER_MUL [HORNER_STEPS] = '{
      32'((64'd1 << RECIP_SHIFT) / 64'd110),
      32'((64'd1 << RECIP_SHIFT) / 64'd72),
      32'((64'd1 << RECIP_SHIFT) / 64'd42),
      32'((64'd1 << RECIP_SHIFT) / 64'd20),
      32'((64'd1 << RECIP_SHIFT) / 64'd6)
   };

   localparam logic [30:0] WIN_BASE = 31'((64'd42 * 64'd1073741824) / 64'd100);
   localparam logic [6:0]  WIN_DIV  = 7'd25;
   localparam logic [31:0] WIN_MUL  = 32'((64'd1 << RECIP_SHIFT) / 64'd25);

   localparam int DIV_REM_W = 40;
   localparam int DIV_BITS  = 31;

   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic [DIV_REM_W-1:0] divisor;
      logic [DIV_BITS-1:0]  bits;
      logic [DIV_BITS-1:0]  quot;
   } div_lane_type;

   typedef struct packed {
      logic [30:0] z;
      logic [31:0] z2;
      logic [30:0] r;
   } sine_lane_type;

endpackage

// ----- sv/bwsk_div_cell.sv -----
// ---------------------------------------------------------------------------
// bwsk_div_cell
// One restoring division step: shifts in one dividend bit, emits one
// quotient bit and hands the partial remainder to the next cell.
// ---------------------------------------------------------------------------
module bwsk_div_cell (
   input  logic                   clock,
   input  logic                   advance,
   input  bwsk_pkg::div_lane_type prev_lane,
   output bwsk_pkg::div_lane_type next_lane
);
   import bwsk_pkg::*;

   logic [DIV_REM_W:0] trial;
   logic [DIV_REM_W:0] diff;
   logic               fits;
   div_lane_type       lane_in;
   div_lane_type       lane_ff;

   always_comb begin
      trial = {prev_lane.rem, prev_lane.bits[DIV_BITS-1]};
      diff  = trial - {1'b0, prev_lane.divisor};
      fits  = trial >= {1'b0, prev_lane.divisor};
      lane_in.rem     = fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      lane_in.divisor = prev_lane.divisor;
      lane_in.bits    = {prev_lane.bits[DIV_BITS-2:0], 1'b0};
      lane_in.quot    = {prev_lane.quot[DIV_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

// ----- sv/bwsk_horner_cell.sv -----
// ---------------------------------------------------------------------------
// bwsk_horner_cell
// One Horner step of the sine series, r = 1 - (z2 * r) / d, in three
// register stages: product, reciprocal multiply, correction.
// ---------------------------------------------------------------------------
module bwsk_horner_cell (
   input  logic                    clock,
   input  logic                    advance,
   input  logic [6:0]              d_value,
   input  logic [31:0]             m_value,
   input  bwsk_pkg::sine_lane_type prev_lane,
   output bwsk_pkg::sine_lane_type next_lane
);
   import bwsk_pkg::*;

   logic [62:0]   prod_a;
   logic [31:0]   n_a_in;
   logic [30:0]   z_a_ff;
   logic [31:0]   z2_a_ff;
   logic [31:0]   n_a_ff;
   logic [63:0]   prod_b;
   logic [29:0]   qe_b_in;
   logic [30:0]   z_b_ff;
   logic [31:0]   z2_b_ff;
   logic [31:0]   n_b_ff;
   logic [29:0]   qe_b_ff;
   logic [36:0]   back_c;
   logic [31:0]   rem_c;
   logic [29:0]   q_c;
   sine_lane_type lane_in;
   sine_lane_type lane_ff;

   always_comb begin
      prod_a  = 63'(prev_lane.z2) * 63'(prev_lane.r);
      n_a_in  = prod_a[61:30];
      prod_b  = 64'(n_a_ff) * 64'(m_value);
      qe_b_in = prod_b[63:RECIP_SHIFT];
      back_c  = 37'(qe_b_ff) * 37'(d_value);
      rem_c   = n_b_ff - back_c[31:0];
      q_c     = (rem_c >= 32'(d_value)) ? qe_b_ff + 30'd1 : qe_b_ff;
      lane_in.z  = z_b_ff;
      lane_in.z2 = z2_b_ff;
      lane_in.r  = Q30_ONE - 31'(q_c);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_a_ff  <= prev_lane.z;
         z2_a_ff <= prev_lane.z2;
         n_a_ff  <= n_a_in;
         z_b_ff  <= z_a_ff;
         z2_b_ff <= z2_a_ff;
         n_b_ff  <= n_a_ff;
         qe_b_ff <= qe_b_in;
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

// ----- sv/bwsk_sine.sv -----
// ---------------------------------------------------------------------------
// bwsk_sine
// Pipelined sin(pi * s) in Q30 for s in Q16, 0 <= s <= 0.5: angle scaling,
// squaring, a row of Horner cells and the final multiply.
// ---------------------------------------------------------------------------
module bwsk_sine (
   input  logic        clock,
   input  logic        advance,
   input  logic [15:0] angle,
   output logic [30:0] sine
);
   import bwsk_pkg::*;

   logic [47:0]   zp;
   logic [30:0]   z_in;
   logic [30:0]   z_ff;
   logic [61:0]   zz;
   sine_lane_type head_in;
   sine_lane_type head_ff;
   sine_lane_type lane [HORNER_STEPS+1];
   logic [61:0]   zr;
   logic [30:0]   sine_in;
   logic [30:0]   sine_ff;

   always_comb begin
      zp         = 48'(angle) * 48'(PI_Q30);
      z_in       = zp[46:16];
      zz         = 62'(z_ff) * 62'(z_ff);
      head_in.z  = z_ff;
      head_in.z2 = zz[61:30];
      head_in.r  = Q30_ONE;
      zr         = 62'(lane[HORNER_STEPS].z) * 62'(lane[HORNER_STEPS].r);
      sine_in    = zr[60:30];
   end

   assign lane[0] = head_ff;

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      bwsk_horner_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .d_value   (HORNER_DIV[i]),
         .m_value   (HORNER_MUL[i]),
         .prev_lane (lane[i]),
         .next_lane (lane[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff    <= z_in;
         head_ff <= head_in;
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

// ----- sv/blackman_windowed_sinc_kernel.sv -----
// ---------------------------------------------------------------------------
// blackman_windowed_sinc_kernel
// Blackman window and windowed sinc at a Q8.16 position, both in Q1.16.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_position (Q8.16)
//   rsp      out        rsp_valid / rsp_stall  rsp_kernel_value, rsp_window_value
//   csr      in         csr_valid / csr_ready  csr_half_width
//
// One position per cycle while req_stall is low. A result passes the front
// stage, the 18-stage sine pipeline, the 31-cell sinc divider, the kernel
// product and the output register; the window path (17-cell ratio divider,
// cosines, combine) runs alongside.
// Reset empties the pipeline and loads half_width with 4.
// req_stall rises only while the last stage holds a result and the output
// register is stalled.
// ---------------------------------------------------------------------------
module blackman_windowed_sinc_kernel (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [24:0] req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_kernel_value,
   output logic        [16:0] rsp_window_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [7:0]  csr_half_width
);
   import bwsk_pkg::*;

   localparam int A_DEPTH    = SINE_LATENCY;
   localparam int WDIV_STEPS = A_DEPTH - 1;
   localparam int B_DEPTH    = DIV_BITS;
   localparam int WIN_DELAY  = B_DEPTH - SINE_LATENCY - 3;
   localparam int PIPE_DEPTH = A_DEPTH + B_DEPTH + 2;

   typedef struct packed {
      logic        support;
      logic        azero;
      logic        neg;
      logic [24:0] a;
   } side_a_type;

   typedef struct packed {
      logic support;
      logic azero;
      logic neg;
      logic neg1;
      logic neg2;
   } side_b_type;

   logic [7:0]            hw_ff;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  advance;

   // front stage
   logic [7:0]   taps;
   logic [24:0]  abs_a;
   logic [25:0]  wnum;
   logic [15:0]  pl;
   side_a_type   f_side_in;
   side_a_type   f_side_ff;
   logic [15:0]  f_angle_in;
   logic [15:0]  f_angle_ff;
   div_lane_type f_wdiv_in;
   div_lane_type f_wdiv_ff;

   // first phase
   side_a_type   sa_ff [A_DEPTH];
   div_lane_type wdiv_lane [WDIV_STEPS+1];
   logic [30:0]  ssine;
   logic [56:0]  dprod;
   logic [39:0]  dsinc_in;
   logic [39:0]  dsinc_ff;
   logic [16:0]  t_raw;
   logic [16:0]  t_val;
   logic [17:0]  u_raw;
   logic [16:0]  u_val;
   logic [15:0]  arg1_in;
   logic [15:0]  arg1_ff;
   logic         neg1_in;
   logic         neg1_ff;
   logic [15:0]  arg2_in;
   logic [15:0]  arg2_ff;
   logic         neg2_in;
   logic         neg2_ff;

   // second phase
   side_b_type   sb_ff [B_DEPTH];
   div_lane_type sdiv_lane [B_DEPTH+1];
   logic [30:0]  cos1_s;
   logic [30:0]  cos2_s;
   logic [31:0]  n2_in;
   logic [63:0]  qp2;
   logic [29:0]  qe2_in;
   logic [29:0]  m1_ff;
   logic [31:0]  n2_ff;
   logic [29:0]  qe2_ff;
   logic [36:0]  back2;
   logic [31:0]  rem2;
   logic [29:0]  q2_in;
   logic [29:0]  q2_ff;
   logic [29:0]  m1b_ff;
   logic signed [33:0] term1;
   logic signed [33:0] term2;
   logic signed [33:0] wsum;
   logic [30:0]  win_in;
   logic [30:0]  win_ff;
   logic [30:0]  wd_ff [WIN_DELAY];

   // final stages
   logic [30:0]  sinc_mag;
   logic [60:0]  prod_in;
   logic [60:0]  c_prod_ff;
   logic [30:0]  c_win_ff;
   logic         c_support_ff;
   logic         c_neg_ff;
   logic [16:0]  kmag;
   logic [31:0]  wround;
   logic [16:0]  wout;
   logic signed [17:0] kernel_in;
   logic [16:0]  window_in;
   logic         rsp_valid_ff;
   logic signed [17:0] kernel_ff;
   logic [16:0]  window_ff;

   assign csr_ready = 1'b1;
   assign advance   = !(valid_ff[PIPE_DEPTH-1] && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= HALF_WIDTH_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            hw_ff <= csr_half_width;
         end
         if (advance) begin
            valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
         end
         if (advance && valid_ff[PIPE_DEPTH-1]) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // front stage: magnitude, support, folded sinc angle, divider setup
   always_comb begin
      if (hw_ff == 8'd0) begin
         taps = 8'd1;
      end else if (hw_ff > MAX_HALF_WIDTH) begin
         taps = MAX_HALF_WIDTH;
      end else begin
         taps = hw_ff;
      end
      abs_a = req_position[24] ? (25'd0 - $unsigned(req_position))
                               : $unsigned(req_position);
      wnum  = {abs_a, 1'b0} + 26'(taps);
      pl    = abs_a[15:0];
      f_side_in.support = abs_a <= {1'b0, taps, 16'd0};
      f_side_in.azero   = abs_a == 25'd0;
      f_side_in.neg     = abs_a[16];
      f_side_in.a       = abs_a;
      f_angle_in = (pl <= 16'd32768) ? pl : 16'(17'h1_0000 - {1'b0, pl});
      f_wdiv_in.rem     = DIV_REM_W'(wnum[25:17]);
      f_wdiv_in.divisor = DIV_REM_W'({taps, 1'b0});
      f_wdiv_in.bits    = {wnum[16:0], 14'd0};
      f_wdiv_in.quot    = '0;
   end

   // first phase: window ratio divider, sinc sine, sinc denominator
   assign wdiv_lane[0] = f_wdiv_ff;

   for (genvar i = 0; i < WDIV_STEPS; i++) begin : g_wdiv
      bwsk_div_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_lane (wdiv_lane[i]),
         .next_lane (wdiv_lane[i+1])
      );
   end

   bwsk_sine u_sinc_sine (
      .clock   (clock),
      .advance (advance),
      .angle   (f_angle_ff),
      .sine    (ssine)
   );

   always_comb begin
      dprod    = 57'(PI_Q30) * 57'(sa_ff[A_DEPTH-2].a);
      dsinc_in = dprod[55:16];
      t_raw    = wdiv_lane[WDIV_STEPS].quot[16:0];
      t_val    = (t_raw > 17'd65536) ? 17'd65536 : t_raw;
      u_raw    = {t_val, 1'b0};
      u_val    = (u_raw > 18'd65536) ? 17'(18'd131072 - u_raw) : u_raw[16:0];
      neg1_in  = t_val > 17'd32768;
      arg1_in  = neg1_in ? 16'(t_val - 17'd32768) : 16'(17'd32768 - t_val);
      neg2_in  = u_val > 17'd32768;
      arg2_in  = neg2_in ? 16'(u_val - 17'd32768) : 16'(17'd32768 - u_val);
   end

   // second phase: window cosines and combine, sinc divider
   bwsk_sine u_cos1_sine (
      .clock   (clock),
      .advance (advance),
      .angle   (arg1_ff),
      .sine    (cos1_s)
   );

   bwsk_sine u_cos2_sine (
      .clock   (clock),
      .advance (advance),
      .angle   (arg2_ff),
      .sine    (cos2_s)
   );

   always_comb begin
      sdiv_lane[0].rem     = DIV_REM_W'(ssine[30:1]);
      sdiv_lane[0].divisor = dsinc_ff;
      sdiv_lane[0].bits    = {ssine[0], 30'd0};
      sdiv_lane[0].quot    = '0;
   end

   for (genvar i = 0; i < B_DEPTH; i++) begin : g_sdiv
      bwsk_div_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_lane (sdiv_lane[i]),
         .next_lane (sdiv_lane[i+1])
      );
   end

   always_comb begin
      n2_in  = {cos2_s, 1'b0};
      qp2    = 64'(n2_in) * 64'(WIN_MUL);
      qe2_in = qp2[63:RECIP_SHIFT];
      back2  = 37'(qe2_ff) * 37'(WIN_DIV);
      rem2   = n2_ff - back2[31:0];
      q2_in  = (rem2 >= 32'(WIN_DIV)) ? qe2_ff + 30'd1 : qe2_ff;
      term1  = sb_ff[SINE_LATENCY+1].neg1 ? -$signed(34'(m1b_ff))
                                          : $signed(34'(m1b_ff));
      term2  = sb_ff[SINE_LATENCY+1].neg2 ? -$signed(34'(q2_ff))
                                          : $signed(34'(q2_ff));
      wsum   = $signed(34'(WIN_BASE)) + term1 + term2;
      if (wsum < 0) begin
         win_in = '0;
      end else if (wsum > $signed(34'(Q30_ONE))) begin
         win_in = Q30_ONE;
      end else begin
         win_in = wsum[30:0];
      end
   end

   // final stages: kernel product, rounding, saturation, sign
   always_comb begin
      if (sb_ff[B_DEPTH-1].azero) begin
         sinc_mag = Q30_ONE;
      end else if (sdiv_lane[B_DEPTH].quot > DIV_BITS'(Q30_ONE)) begin
         sinc_mag = Q30_ONE;
      end else begin
         sinc_mag = sdiv_lane[B_DEPTH].quot[30:0];
      end
      prod_in = 61'(sinc_mag) * 61'(wd_ff[WIN_DELAY-1]) + (61'd1 << 43);
      kmag    = (c_prod_ff[60:44] > 17'd65536) ? 17'd65536 : c_prod_ff[60:44];
      wround  = 32'(c_win_ff) + 32'd8192;
      wout    = (wround[30:14] > 17'd65536) ? 17'd65536 : wround[30:14];
      if (!c_support_ff) begin
         kernel_in = '0;
         window_in = '0;
      end else begin
         kernel_in = c_neg_ff ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
         window_in = wout;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_side_ff  <= f_side_in;
         f_angle_ff <= f_angle_in;
         f_wdiv_ff  <= f_wdiv_in;
         sa_ff[0]   <= f_side_ff;
         for (int i = 1; i < A_DEPTH; i++) begin
            sa_ff[i] <= sa_ff[i-1];
         end
         dsinc_ff <= dsinc_in;
         arg1_ff  <= arg1_in;
         neg1_ff  <= neg1_in;
         arg2_ff  <= arg2_in;
         neg2_ff  <= neg2_in;
         sb_ff[0] <= '{support: sa_ff[A_DEPTH-1].support,
                       azero:   sa_ff[A_DEPTH-1].azero,
                       neg:     sa_ff[A_DEPTH-1].neg,
                       neg1:    neg1_ff,
                       neg2:    neg2_ff};
         for (int i = 1; i < B_DEPTH; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
         m1_ff    <= cos1_s[30:1];
         n2_ff    <= n2_in;
         qe2_ff   <= qe2_in;
         m1b_ff   <= m1_ff;
         q2_ff    <= q2_in;
         win_ff   <= win_in;
         wd_ff[0] <= win_ff;
         for (int i = 1; i < WIN_DELAY; i++) begin
            wd_ff[i] <= wd_ff[i-1];
         end
         c_prod_ff    <= prod_in;
         c_win_ff     <= wd_ff[WIN_DELAY-1];
         c_support_ff <= sb_ff[B_DEPTH-1].support;
         c_neg_ff     <= sb_ff[B_DEPTH-1].neg;
         if (valid_ff[PIPE_DEPTH-1]) begin
            kernel_ff <= kernel_in;
            window_ff <= window_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = kernel_ff;
   assign rsp_window_value = window_ff;

endmodule

// ----- dv/blackman_windowed_sinc_kernel_checker.sv -----
// ---------------------------------------------------------------------------
// blackman_windowed_sinc_kernel_checker
// Watches the position and result channels, computes the expected window
// and windowed sinc for every position transfer, and compares each result
// transfer field by field in order. Tracks the half-width register from the
// configuration channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blackman_windowed_sinc_kernel_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [24:0] req_position,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_kernel_value,
   input  logic        [16:0] rsp_window_value,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic        [7:0]  csr_half_width,
   output int                 error_count,
   output int                 pending_count
);
   import bwsk_pkg::*;

   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] PI_VAL  = 64'd3373259426;

   typedef struct packed {
      logic signed [17:0] kernel_value;
      logic        [16:0] window_value;
   } kernel_result_type;

   kernel_result_type expected_results[$];
   logic [7:0]        half_width_reg;

   function automatic logic [63:0] sin_pi_q30(input logic [63:0] s);
      logic [63:0] z, z2, r;
      z  = (s * PI_VAL) >> 16;
      z2 = (z * z) >> 30;
      r  = ONE_Q30 - z2 / 110;
      r  = ONE_Q30 - ((z2 * r) >> 30) / 72;
      r  = ONE_Q30 - ((z2 * r) >> 30) / 42;
      r  = ONE_Q30 - ((z2 * r) >> 30) / 20;
      r  = ONE_Q30 - ((z2 * r) >> 30) / 6;
      return (z * r) >> 30;
   endfunction

   function automatic longint cos_pi_q30(input logic [63:0] t);
      if (t <= 64'd32768) begin
         return longint'(sin_pi_q30(64'd32768 - t));
      end
      return -longint'(sin_pi_q30(t - 64'd32768));
   endfunction

   function automatic kernel_result_type windowed_sinc(input logic [24:0] pos,
                                                       input logic [7:0] hw);
      kernel_result_type res;
      logic [63:0]       taps, a, t, u, p, h, smag, sinc_mag, win, kmag, wout;
      longint            c1, c2, w;
      logic              neg;
      neg  = 1'b0;
      taps = 64'(hw);
      if (taps == 0) begin
         taps = 1;
      end
      if (taps > 64'(MAX_HALF_WIDTH)) begin
         taps = 64'(MAX_HALF_WIDTH);
      end
      a = pos[24] ? (64'h2000000 - 64'(pos)) : 64'(pos);
      if (a > taps * 65536) begin
         return '0;
      end
      t = (a * 2 + taps) / (taps * 2);
      if (t > 65536) begin
         t = 65536;
      end
      u = t * 2;
      if (u > 65536) begin
         u = 131072 - u;
      end
      c1 = cos_pi_q30(t);
      c2 = cos_pi_q30(u);
      w  = longint'((64'd42 * ONE_Q30) / 100) + c1 / 2 + (c2 * 2) / 25;
      if (w < 0) begin
         w = 0;
      end
      if (w > longint'(ONE_Q30)) begin
         w = longint'(ONE_Q30);
      end
      win  = 64'(w);
      wout = (win + 8192) >> 14;
      if (wout > 65536) begin
         wout = 65536;
      end
      if (a == 0) begin
         sinc_mag = ONE_Q30;
      end else begin
         p = a & 64'h1FFFF;
         if (p >= 65536) begin
            p   = p - 65536;
            neg = 1'b1;
         end
         h        = (p <= 32768) ? p : (65536 - p);
         smag     = sin_pi_q30(h);
         sinc_mag = (smag << 30) / ((PI_VAL * a) >> 16);
         if (sinc_mag > ONE_Q30) begin
            sinc_mag = ONE_Q30;
         end
      end
      kmag = (sinc_mag * win + (64'd1 << 43)) >> 44;
      if (kmag > 65536) begin
         kmag = 65536;
      end
      res.kernel_value = neg ? -18'(kmag) : 18'(kmag);
      res.window_value = 17'(wout);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      kernel_result_type want;
      if (reset) begin
         half_width_reg <= HALF_WIDTH_RESET;
         expected_results.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            half_width_reg <= csr_half_width;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_kernel_value !== want.kernel_value) begin
                  report_mismatch($sformatf("kernel_value %0d, expected %0d",
                                            rsp_kernel_value, want.kernel_value));
               end
               if (rsp_window_value !== want.window_value) begin
                  report_mismatch($sformatf("window_value %0d, expected %0d",
                                            rsp_window_value, want.window_value));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(windowed_sinc(req_position, half_width_reg));
         end
         pending_count = expected_results.size();
      end
   end

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Drives positions and half-width settings into the Blackman-windowed sinc
// kernel with random idle cycles and result stalls; the checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int LATENCY = 52;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [24:0] req_position;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [17:0] rsp_kernel_value;
   logic        [16:0] rsp_window_value;
   logic               csr_valid;
   logic               csr_ready;
   logic        [7:0]  csr_half_width;
   int                 error_count;
   int                 pending_count;
   bit                 idling_on;

   blackman_windowed_sinc_kernel i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kernel_value (rsp_kernel_value),
      .rsp_window_value (rsp_window_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_half_width   (csr_half_width)
   );

   blackman_windowed_sinc_kernel_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kernel_value (rsp_kernel_value),
      .rsp_window_value (rsp_window_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_half_width   (csr_half_width),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 25);
      end
   end

   task automatic send_position(input logic signed [24:0] pos);
      while (idling_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_half_width(input logic [7:0] value);
      drain_results();
      csr_valid      <= 1'b1;
      csr_half_width <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [24:0] random_position(input int taps);
      int k;
      k = $urandom_range(99);
      if (k < 70) begin
         return 25'(int'($urandom_range(2 * taps * 65536)) - taps * 65536);
      end else if (k < 80) begin
         return 25'(($urandom_range(2 * taps) - taps) * 32768);
      end
      return 25'($urandom);
   endfunction

   initial begin
      logic [7:0] settings[6];
      int         taps;
      settings     = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd129, 8'd7};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_position = '0;
      csr_valid    = 1'b0;
      csr_half_width = '0;
      idling_on    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset half-width
      repeat (6) send_position(25'sd0);
      send_position(25'sd1);
      send_position(-25'sd1);
      send_position(25'sd16777215);
      send_position(-25'sd16777216);
      send_position(25'sd262144);
      send_position(25'sd262145);
      send_position(-25'sd262144);
      send_position(25'sd65536);
      send_position(25'sd98304);
      send_position(-25'sd131072);
      send_position(25'sd32768);
      send_position(25'sd196608);
      send_position(25'sd245760);

      // unstalled stretch
      repeat (40) send_position(random_position(4));
      idling_on = 1'b1;

      foreach (settings[s]) begin
         write_half_width(settings[s]);
         taps = (settings[s] == 0) ? 1 : (settings[s] > 128 ? 128 : settings[s]);
         send_position(25'(taps * 65536));
         send_position(-25'(taps * 65536 + 1));
         repeat (60) send_position(random_position(taps));
      end
      repeat ($urandom_range(20, 40)) send_position(random_position(128));

      drain_results();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
